FILE: rtl/lpq_pkg.sv
// ----------------------------------------------------------------------------
// lpq_pkg: shared types and constants for the lottery priority ready queues
// Command codes, payload structs, controller states and the command bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package lpq_pkg;
	localparam int TASKS  = 16;
	localparam int QUEUES = 8;
	localparam int LEVELS = 5;
	localparam int TW = $clog2(TASKS);
	localparam int QW = $clog2(QUEUES);
	localparam int LW = TW + 1;               // link width, code TASKS is null
	localparam int MW = QW + 1;               // tag width, QUEUES means none
	localparam logic [LW-1:0] NIL = LW'(TASKS);
	localparam logic [MW-1:0] NO_Q = MW'(QUEUES);

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0, CMD_PUSH_PRI = 3'd1, CMD_POP = 3'd2,
		CMD_LOTTERY = 3'd3, CMD_REMOVE = 3'd4, CMD_TEST = 3'd5
	} cmd_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOTIN = 2'd2;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] task_req;
		logic [2:0] queue_sel;
		logic [2:0] priority_req;
		logic [6:0] rand_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] task_out;
		logic       found;
		logic [3:0] next_task;
		logic       next_valid;
		logic [7:0] empty_mask;
	} out_word_t;

	typedef enum logic [1:0] {S_IDLE, S_UNLINK, S_APPEND, S_OUT} state_t;

	typedef struct packed {
		logic capture;   // latch the input word, decode
		logic unlink;    // unlink the latched target task
		logic append;    // append the latched task to its queue
		logic result;    // load the output register
	} ctl_t;

	typedef struct packed {
		logic do_unlink;
		logic do_append;
	} sts_t;

	function automatic logic [QW:0] lottery_level(input logic [6:0] r);
		if (r >= 7'd1 && r <= 7'd10)  return (QW+1)'(0);
		if (r >= 7'd12 && r <= 7'd22) return (QW+1)'(1);
		if (r >= 7'd24 && r <= 7'd36) return (QW+1)'(2);
		if (r >= 7'd38 && r <= 7'd52) return (QW+1)'(3);
		if (r >= 7'd54 && r <= 7'd71) return (QW+1)'(4);
		return (QW+1)'(LEVELS);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/lpq_ctrl.sv
// ----------------------------------------------------------------------------
// lpq_ctrl: command sequencer
// Steps one word through decode, unlink, append and result.
// ----------------------------------------------------------------------------
`default_nettype none
module lpq_ctrl (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	input  lpq_pkg::sts_t sts,
	output lpq_pkg::ctl_t ctl
);
	lpq_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.result)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			lpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d = lpq_pkg::S_UNLINK;
				end
			end
			lpq_pkg::S_UNLINK: begin
				ctl.unlink = sts.do_unlink;
				state_d = lpq_pkg::S_APPEND;
			end
			lpq_pkg::S_APPEND: begin
				ctl.append = sts.do_append;
				state_d = lpq_pkg::S_OUT;
			end
			lpq_pkg::S_OUT: begin
				// hold until the previous result has left
				if (!out_valid_q || out_ready) begin
					ctl.result = 1'b1;
					state_d = lpq_pkg::S_IDLE;
				end
			end
			default: state_d = lpq_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/lpq_dp.sv
// ----------------------------------------------------------------------------
// lpq_dp: queue datapath
// Link tables, member tags, head and tail pointers and result forming.
// ----------------------------------------------------------------------------
`default_nettype none
module lpq_dp (
	input  wire  clk,
	input  wire  arst_n,
	input  lpq_pkg::in_word_t  in_word,
	input  lpq_pkg::ctl_t      ctl,
	output lpq_pkg::sts_t      sts,
	output lpq_pkg::out_word_t out_word
);
	localparam int TW = lpq_pkg::TW;
	localparam int QW = lpq_pkg::QW;
	localparam int LW = lpq_pkg::LW;
	localparam int MW = lpq_pkg::MW;

	logic [LW-1:0] next_q [lpq_pkg::TASKS];
	logic [LW-1:0] prev_q [lpq_pkg::TASKS];
	logic [MW-1:0] tag_q  [lpq_pkg::TASKS];
	logic [LW-1:0] head_q [lpq_pkg::QUEUES];
	logic [LW-1:0] tail_q [lpq_pkg::QUEUES];

	// latched decode of the word in hand
	logic [TW-1:0] tgt_q;       // task to unlink
	logic [TW-1:0] app_task_q;
	logic [QW-1:0] app_q_q;
	logic          do_unlink_q, do_append_q;
	logic [1:0]    status_q;
	logic [3:0]    task_out_q, next_task_q;
	logic          found_q, next_valid_q;
	lpq_pkg::out_word_t out_q;

	// capture decode
	logic [2:0]    cmd;
	logic [TW-1:0] tr;
	logic [QW-1:0] qs;
	logic [2:0]    pri;
	logic [QW:0]   lv;
	logic [LW-1:0] lv_head;
	logic [LW-1:0] qs_head;
	logic [MW-1:0] tr_tag;
	logic [TW-1:0] d_tgt, d_app_task;
	logic [QW-1:0] d_app_q;
	logic          d_unl, d_app, d_found, d_nv;
	logic [1:0]    d_status;
	logic [3:0]    d_tout, d_next;

	always_comb begin
		cmd     = in_word.command;
		tr      = TW'(in_word.task_req);
		qs      = QW'(in_word.queue_sel);
		pri     = in_word.priority_req;
		lv      = lpq_pkg::lottery_level(in_word.rand_value);
		lv_head = head_q[QW'(lv)];
		qs_head = head_q[qs];
		tr_tag  = tag_q[tr];
		d_tgt = tr; d_app_task = tr; d_app_q = qs;
		d_unl = 1'b0; d_app = 1'b0; d_found = 1'b0; d_nv = 1'b0;
		d_status = lpq_pkg::ST_DONE; d_tout = '0; d_next = '0;
		if (pri < 3'd1) pri = 3'd1;
		if (pri > 3'(lpq_pkg::LEVELS)) pri = 3'(lpq_pkg::LEVELS);
		case (cmd)
			lpq_pkg::CMD_PUSH, lpq_pkg::CMD_PUSH_PRI: begin
				if (cmd == lpq_pkg::CMD_PUSH_PRI)
					d_app_q = QW'(pri - 3'd1);
				d_unl = (tr_tag != lpq_pkg::NO_Q);
				d_app = 1'b1;
			end
			lpq_pkg::CMD_POP: begin
				if (qs_head == lpq_pkg::NIL) begin
					d_status = lpq_pkg::ST_EMPTY;
				end else begin
					d_tgt  = TW'(qs_head);
					d_tout = 4'(qs_head);
					d_unl  = 1'b1;
				end
			end
			lpq_pkg::CMD_LOTTERY: begin
				if (lv >= (QW+1)'(lpq_pkg::LEVELS) || lv_head == lpq_pkg::NIL) begin
					d_status = lpq_pkg::ST_EMPTY;
				end else begin
					d_tgt  = TW'(lv_head);
					d_tout = 4'(lv_head);
					d_unl  = 1'b1;
				end
			end
			lpq_pkg::CMD_REMOVE: begin
				if (tr_tag != MW'(qs)) begin
					d_status = lpq_pkg::ST_NOTIN;
				end else begin
					d_unl = 1'b1;
					if (next_q[tr] != lpq_pkg::NIL) begin
						d_nv   = 1'b1;
						d_next = 4'(next_q[tr]);
					end
				end
			end
			lpq_pkg::CMD_TEST: d_found = (tr_tag == MW'(qs));
			default: ;
		endcase
	end

	// unlink path on the latched target, and the append tail lookup
	logic [MW-1:0] u_tag;
	logic [LW-1:0] u_p, u_n;
	logic [LW-1:0] a_tl;
	always_comb begin
		u_tag = tag_q[tgt_q];
		u_p   = prev_q[tgt_q];
		u_n   = next_q[tgt_q];
		a_tl  = tail_q[app_q_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpq_pkg::TASKS; i++) tag_q[i] <= lpq_pkg::NO_Q;
			for (int i = 0; i < lpq_pkg::QUEUES; i++) begin
				head_q[i] <= lpq_pkg::NIL;
				tail_q[i] <= lpq_pkg::NIL;
			end
		end else if (ctl.unlink) begin
			if (u_p == lpq_pkg::NIL) head_q[QW'(u_tag)] <= u_n;
			if (u_n == lpq_pkg::NIL) tail_q[QW'(u_tag)] <= u_p;
			tag_q[tgt_q] <= lpq_pkg::NO_Q;
		end else if (ctl.append) begin
			if (a_tl == lpq_pkg::NIL) head_q[app_q_q] <= LW'(app_task_q);
			tail_q[app_q_q] <= LW'(app_task_q);
			tag_q[app_task_q] <= MW'(app_q_q);
		end
	end

	// link tables: no reset, read only for queued tasks
	always_ff @(posedge clk) begin
		if (ctl.unlink) begin
			if (u_p != lpq_pkg::NIL) next_q[TW'(u_p)] <= u_n;
			if (u_n != lpq_pkg::NIL) prev_q[TW'(u_n)] <= u_p;
			next_q[tgt_q] <= lpq_pkg::NIL;
			prev_q[tgt_q] <= lpq_pkg::NIL;
		end else if (ctl.append) begin
			prev_q[app_task_q] <= a_tl;
			next_q[app_task_q] <= lpq_pkg::NIL;
			if (a_tl != lpq_pkg::NIL) next_q[TW'(a_tl)] <= LW'(app_task_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			tgt_q <= d_tgt; app_task_q <= d_app_task; app_q_q <= d_app_q;
			do_unlink_q <= d_unl; do_append_q <= d_app;
			status_q <= d_status; task_out_q <= d_tout; found_q <= d_found;
			next_task_q <= d_next; next_valid_q <= d_nv;
		end
		if (ctl.result) begin
			out_q.status     <= status_q;
			out_q.task_out   <= task_out_q;
			out_q.found      <= found_q;
			out_q.next_task  <= next_task_q;
			out_q.next_valid <= next_valid_q;
			for (int i = 0; i < 8; i++)
				out_q.empty_mask[i] <= (i < lpq_pkg::QUEUES) ?
					(head_q[QW'(i)] == lpq_pkg::NIL) : 1'b0;
		end
	end

	assign sts.do_unlink = do_unlink_q;
	assign sts.do_append = do_append_q;
	assign out_word = out_q;
endmodule
`default_nettype wire

FILE: rtl/lottery_priority_ready_queues.sv
// ----------------------------------------------------------------------------
// lottery_priority_ready_queues: multilevel lottery ready queues
// Doubly linked FIFO queues of task IDs with push, pop, lottery pop,
// remove and membership test.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | word
//  in      | in_valid  | in_ready  | in_word  (lpq_pkg::in_word_t)
//  out     | out_valid | out_ready | out_word (lpq_pkg::out_word_t)
//
//  A word passes through four steps: capture and decode, unlink, append,
//  result. The link tables have one write path, so unlink and append of a
//  move are split over separate steps; the sequencer takes a new word only
//  once the last one has passed its result step.
//  Reset empties every queue and marks every task unqueued.
//  A result waiting in the output register stalls only the result step.
`default_nettype none
module lottery_priority_ready_queues (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  lpq_pkg::in_word_t in_word,
	output logic out_valid,
	input  wire  out_ready,
	output lpq_pkg::out_word_t out_word
);
	lpq_pkg::ctl_t ctl;
	lpq_pkg::sts_t sts;

	// sequence the word through the datapath
	lpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .ctl(ctl)
	);

	// hold the queue state and form the result
	lpq_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_word(in_word), .ctl(ctl), .sts(sts), .out_word(out_word)
	);
endmodule
`default_nettype wire

FILE: dv/lottery_priority_ready_queues_test.sv
// ----------------------------------------------------------------------------
// lottery_priority_ready_queues_test: self-checking bench for the ready queues
// Drives directed and random command words with random gaps on both sides,
// predicts each result from a behavioural copy of the linked queues and
// checks every field of every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none
module lottery_priority_ready_queues_test;
	import lpq_pkg::*;

	localparam int NTASK  = 16;
	localparam int NQUEUE = 8;
	localparam int NLEVEL = 5;
	localparam logic [4:0] NOLINK = 5'd16;
	localparam logic [3:0] UNQUEUED = 4'd8;

	// Queue model plus the list of result words still owed by the block.
	class queue_scoreboard;
		logic [4:0] succ [NTASK];
		logic [4:0] pred [NTASK];
		logic [3:0] owner [NTASK];
		logic [4:0] first [NQUEUE];
		logic [4:0] last [NQUEUE];
		out_word_t owed [$];
		int errors;
		int checked;

		function new();
			for (int i = 0; i < NTASK; i++) begin
				succ[i] = NOLINK;
				pred[i] = NOLINK;
				owner[i] = UNQUEUED;
			end
			for (int i = 0; i < NQUEUE; i++) begin
				first[i] = NOLINK;
				last[i] = NOLINK;
			end
			errors = 0;
			checked = 0;
		endfunction

		function void detach(int t);
			logic [3:0] q;
			logic [4:0] p;
			logic [4:0] n;
			q = owner[t];
			p = pred[t];
			n = succ[t];
			if (q >= UNQUEUED)
				return;
			if (p == NOLINK) first[q] = n; else succ[p] = n;
			if (n == NOLINK) last[q] = p; else pred[n] = p;
			succ[t] = NOLINK;
			pred[t] = NOLINK;
			owner[t] = UNQUEUED;
		endfunction

		function void enqueue(int t, int q);
			logic [4:0] tl;
			detach(t);
			tl = last[q];
			pred[t] = tl;
			succ[t] = NOLINK;
			if (tl == NOLINK) first[q] = 5'(t); else succ[tl] = 5'(t);
			last[q] = 5'(t);
			owner[t] = 4'(q);
		endfunction

		function int band(int r);
			if (r >= 1 && r <= 10) return 0;
			if (r >= 12 && r <= 22) return 1;
			if (r >= 24 && r <= 36) return 2;
			if (r >= 38 && r <= 52) return 3;
			if (r >= 54 && r <= 71) return 4;
			return NLEVEL;
		endfunction

		// Note an accepted command word: update the model, queue the result.
		function void note_command(in_word_t w);
			out_word_t r;
			int q;
			int t;
			int p;
			int lv;
			r = '0;
			q = w.queue_sel;
			t = w.task_req;
			case (w.command)
			CMD_PUSH: begin
				enqueue(t, q);
			end
			CMD_PUSH_PRI: begin
				p = w.priority_req;
				if (p < 1) p = 1;
				if (p > NLEVEL) p = NLEVEL;
				enqueue(t, p - 1);
			end
			CMD_POP: begin
				if (first[q] == NOLINK) begin
					r.status = ST_EMPTY;
				end else begin
					r.task_out = first[q][3:0];
					detach(first[q]);
				end
			end
			CMD_LOTTERY: begin
				lv = band(w.rand_value);
				if (lv < NLEVEL && first[lv] != NOLINK) begin
					r.task_out = first[lv][3:0];
					detach(first[lv]);
				end else begin
					r.status = ST_EMPTY;
				end
			end
			CMD_REMOVE: begin
				if (owner[t] != 4'(q)) begin
					r.status = ST_NOTIN;
				end else begin
					if (succ[t] != NOLINK) begin
						r.next_task = succ[t][3:0];
						r.next_valid = 1'b1;
					end
					detach(t);
				end
			end
			CMD_TEST: begin
				r.found = (owner[t] == 4'(q));
			end
			default: begin
			end
			endcase
			for (int i = 0; i < NQUEUE; i++)
				r.empty_mask[i] = (first[i] == NOLINK);
			owed.push_back(r);
		endfunction

		// Compare a result word with the oldest one owed.
		function void check_result(out_word_t a);
			out_word_t e;
			if (owed.size() == 0) begin
				$error("unexpected result word %h", a);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				errors++;
			end
			if (a.task_out !== e.task_out) begin
				$error("task_out: expected %0d, got %0d", e.task_out, a.task_out);
				errors++;
			end
			if (a.found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, a.found);
				errors++;
			end
			if (a.next_task !== e.next_task) begin
				$error("next_task: expected %0d, got %0d", e.next_task, a.next_task);
				errors++;
			end
			if (a.next_valid !== e.next_valid) begin
				$error("next_valid: expected %0d, got %0d", e.next_valid, a.next_valid);
				errors++;
			end
			if (a.empty_mask !== e.empty_mask) begin
				$error("empty_mask: expected %h, got %h", e.empty_mask, a.empty_mask);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;

	queue_scoreboard board;
	bit stimulus_done;
	int sent;
	int cmd_count [8];

	lottery_priority_ready_queues dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one word, hold it until taken, then note it in the scoreboard.
	// Valid is lowered only when no word follows straight away.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		board.note_command(w);
		cmd_count[w.command]++;
		sent++;
	endtask

	// Build a word; fields unused by the command carry whatever the caller passes.
	function automatic in_word_t make_word(cmd_t c, int t, int q, int p, int r);
		in_word_t w;
		w.command = c;
		w.task_req = 4'(t);
		w.queue_sel = 3'(q);
		w.priority_req = 3'(p);
		w.rand_value = 7'(r);
		return w;
	endfunction

	function automatic in_word_t random_word();
		int sel;
		int r;
		sel = $urandom_range(0, 99);
		r = ($urandom_range(0, 19) == 0) ? $urandom_range(72, 127) : $urandom_range(0, 71);
		// Weight towards pushes so that queues fill and pops find work.
		if (sel < 30)
			return make_word(CMD_PUSH, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		else if (sel < 50)
			return make_word(CMD_PUSH_PRI, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		else if (sel < 62)
			return make_word(CMD_POP, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		else if (sel < 76)
			return make_word(CMD_LOTTERY, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		else if (sel < 88)
			return make_word(CMD_REMOVE, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		else if (sel < 97)
			return make_word(CMD_TEST, $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), r);
		return make_word(cmd_t'($urandom_range(6, 7)), $urandom_range(0, 15),
			$urandom_range(0, 7), $urandom_range(0, 7), r);
	endfunction

	// Drain side: random stalls, with calm stretches where ready stays high.
	initial begin
		int stall;
		int calm;
		out_ready = 1'b0;
		calm = 0;
		@(posedge arst_n);
		forever begin
			if (calm > 0) begin
				calm--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 15);
				if ($urandom_range(0, 30) == 0)
					calm = $urandom_range(20, 60);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_result(out_word);
		end
	end

	// Main stimulus.
	initial begin
		in_word_t w;
		int waited;
		board = new();
		in_valid = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		stimulus_done = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, lottery draws and misses, fills, moves, removes, tests, unknown codes.
		send_word(make_word(CMD_POP, 0, 7, 0, 0));
		send_word(make_word(CMD_LOTTERY, 15, 0, 7, 5));
		send_word(make_word(CMD_PUSH_PRI, 0, 0, 0, 127));
		send_word(make_word(CMD_PUSH_PRI, 15, 7, 7, 0));
		send_word(make_word(CMD_PUSH_PRI, 3, 0, 3, 0));
		send_word(make_word(CMD_PUSH, 5, 7, 0, 0));
		send_word(make_word(CMD_PUSH, 6, 7, 0, 0));
		send_word(make_word(CMD_PUSH, 7, 7, 0, 0));
		send_word(make_word(CMD_PUSH, 15, 7, 0, 0));   // move from level 4
		send_word(make_word(CMD_TEST, 15, 7, 0, 0));
		send_word(make_word(CMD_TEST, 15, 4, 0, 0));
		send_word(make_word(CMD_REMOVE, 6, 7, 0, 0));  // middle of the list
		send_word(make_word(CMD_REMOVE, 15, 7, 0, 0)); // tail, no successor
		send_word(make_word(CMD_REMOVE, 6, 7, 0, 0));  // no longer queued
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 11));
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 53));
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 1));
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 36));
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 71));
		send_word(make_word(CMD_LOTTERY, 0, 0, 0, 100));
		send_word(make_word(CMD_POP, 0, 7, 0, 0));
		send_word(make_word(cmd_t'(3'd6), 0, 0, 0, 0));
		send_word(make_word(cmd_t'(3'd7), 15, 7, 7, 127));

		for (int i = 0; i < 2000; i++) begin
			// Hold off once, mid run, until the block has drained.
			if (i == 1000) begin
				in_valid <= 1'b0;
				waited = 0;
				while (board.owed.size() != 0 && waited < 10000) begin
					@(posedge clk);
					waited++;
				end
			end
			w = random_word();
			send_word(w);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Finish once all results are in, after a further wait for stray words.
	initial begin
		wait (stimulus_done);
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d command words, %0d results checked.", sent, board.checked);
		$display("Mix: push %0d, push by priority %0d, pop %0d, lottery %0d, remove %0d, test %0d",
			cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
			cmd_count[5]);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("lottery_priority_ready_queues_test passed");
		else
			$display("lottery_priority_ready_queues_test failed");
		$finish;
	end

	// Watchdog, well past the slowest legal run.
	initial begin
		#10000000;
		$display("lottery_priority_ready_queues_test failed");
		$finish;
	end
endmodule
`default_nettype wire
